// ----- design/assert_macros.svh -----
// Assertion helpers included by the top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define CHRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CHRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/chrl_pkg.sv -----
`default_nettype none
package chrl_pkg;

  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 12;
  localparam int HASH_W   = 32;
  localparam int SID_W    = 4;
  localparam int SID_N    = 1 << SID_W;
  localparam int STATUS_W = 2;
  localparam int PIU_W    = 13;
  localparam int SIU_W    = 5;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 1;
  localparam int ENT_W    = HASH_W + SID_W;
  localparam int Q_DEPTH  = 2;

  // function codes on the input channel
  localparam logic [FUNC_W-1:0] FN_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_AVAIL  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVERS = 1'b1;

  // classified operations handed from front to back
  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_AVAIL  = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_EMPTY  = 3'd3;
  localparam logic [2:0] OP_REJECT = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [HASH_W-1:0] hash;   // point hash or key hash
    logic [SID_W-1:0]  sid;
    logic              up;
  } op_t;

  typedef struct packed {
    logic busy;   // lookup scan in progress
    logic pop;    // op taken from the queue this cycle
  } bk_stat_t;

endpackage
`default_nettype wire

// ----- design/chrl_ram.sv -----
`default_nettype none
module chrl_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- design/chrl_front.sv -----
`default_nettype none
module chrl_front #(
  parameter int RING_POINTS = 4096,
  parameter int MAX_SERVERS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [chrl_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [chrl_pkg::SLOT_W-1:0]   in_point_slot,
  input  wire logic [chrl_pkg::HASH_W-1:0]   in_point_hash,
  input  wire logic [chrl_pkg::SID_W-1:0]    in_server_id,
  input  wire logic                          in_server_up,
  input  wire logic [chrl_pkg::HASH_W-1:0]   in_key_hash,
  input  wire logic [chrl_pkg::SIU_W-1:0]    servers_in_use,
  input  wire logic                          ring_empty,
  output logic                               f_valid,
  output chrl_pkg::op_t                      f_op,
  input  wire logic                          q_ready
);

  logic          f_valid_r, f_valid_nxt;
  chrl_pkg::op_t f_op_r, f_op_nxt;
  chrl_pkg::op_t cls;
  logic          accept;
  logic          slot_bad, sid_bad, avail_bad;

  assign slot_bad  = 32'(in_point_slot) >= 32'(RING_POINTS);
  assign sid_bad   = 32'(in_server_id) >= 32'(MAX_SERVERS);
  assign avail_bad = sid_bad || ({1'b0, in_server_id} >= servers_in_use);

  always_comb begin
    cls.slot = in_point_slot;
    cls.hash = in_point_hash;
    cls.sid  = in_server_id;
    cls.up   = in_server_up;
    unique case (in_func)
      chrl_pkg::FN_WRITE:  cls.op = (slot_bad || sid_bad) ? chrl_pkg::OP_REJECT
                                                          : chrl_pkg::OP_WRITE;
      chrl_pkg::FN_AVAIL:  cls.op = avail_bad ? chrl_pkg::OP_REJECT : chrl_pkg::OP_AVAIL;
      chrl_pkg::FN_LOOKUP: begin
        cls.hash = in_key_hash;
        cls.op   = ring_empty ? chrl_pkg::OP_EMPTY : chrl_pkg::OP_LOOKUP;
      end
      default:             cls.op = chrl_pkg::OP_REJECT;
    endcase
  end

  assign in_stall = f_valid_r && !q_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    f_valid_nxt = f_valid_r && !q_ready;
    f_op_nxt    = f_op_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
      f_op_nxt    = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    f_op_r <= f_op_nxt;
  end

  assign f_valid = f_valid_r;
  assign f_op    = f_op_r;

endmodule
`default_nettype wire

// ----- design/chrl_fifo.sv -----
`default_nettype none
module chrl_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire chrl_pkg::op_t din,
  output logic               ready,
  output logic               valid,
  output chrl_pkg::op_t      dout,
  input  wire logic          pop
);

  localparam int QA_W = (chrl_pkg::Q_DEPTH > 1) ? $clog2(chrl_pkg::Q_DEPTH) : 1;
  localparam int QC_W = $clog2(chrl_pkg::Q_DEPTH + 1);

  chrl_pkg::op_t   mem_r [chrl_pkg::Q_DEPTH];
  logic [QA_W-1:0] wp_r, rp_r;
  logic [QC_W-1:0] cnt_r;
  logic            do_push, do_pop;

  function automatic logic [QA_W-1:0] bump(input logic [QA_W-1:0] p);
    bump = (p == QA_W'(chrl_pkg::Q_DEPTH - 1)) ? '0 : p + QA_W'(1);
  endfunction

  assign ready   = cnt_r != QC_W'(chrl_pkg::Q_DEPTH);
  assign valid   = cnt_r != '0;
  assign dout    = mem_r[rp_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= bump(wp_r);
      end
      if (do_pop) begin
        rp_r <= bump(rp_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QC_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QC_W'(1);
      end
    end
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ----- design/chrl_back.sv -----
`default_nettype none
module chrl_back #(
  parameter int RING_POINTS = 4096,
  parameter int MAX_SERVERS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [$clog2(RING_POINTS+1)-1:0]    n_pts,
  input  wire logic                                q_valid,
  input  wire chrl_pkg::op_t                       q_op,
  output chrl_pkg::bk_stat_t                       bk_stat,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [chrl_pkg::STATUS_W-1:0]            out_status,
  output logic [chrl_pkg::SID_W-1:0]               out_chosen_server,
  output logic [chrl_pkg::SLOT_W-1:0]              out_chosen_point
);

  localparam int AW   = $clog2(RING_POINTS);
  localparam int CW   = $clog2(RING_POINTS + 1);
  localparam int AV_W = (MAX_SERVERS < chrl_pkg::SID_N) ? MAX_SERVERS : chrl_pkg::SID_N;

  localparam logic BK_IDLE = 1'b0;
  localparam logic BK_SCAN = 1'b1;

  logic                          state_r, state_nxt;
  logic [AV_W-1:0]               avail_r, avail_nxt;
  logic [chrl_pkg::HASH_W-1:0]   key_r, key_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic                          pend_r, pend_nxt;
  logic [AW-1:0]                 pidx_r, pidx_nxt;
  logic                          found_r, found_nxt;
  logic                          anyv_r, anyv_nxt;
  logic [AW-1:0]                 anyi_r, anyi_nxt;
  logic [chrl_pkg::SID_W-1:0]    anyo_r, anyo_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [chrl_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [chrl_pkg::SID_W-1:0]    out_server_r, out_server_nxt;
  logic [chrl_pkg::SLOT_W-1:0]   out_point_r, out_point_nxt;

  logic [chrl_pkg::SID_N-1:0]    up16, av_ext;
  logic                          out_free, pop;
  logic                          we;
  logic [AW-1:0]                 waddr, raddr;
  logic [chrl_pkg::ENT_W-1:0]    wdata, rdata;
  logic [chrl_pkg::HASH_W-1:0]   rd_hash;
  logic [chrl_pkg::SID_W-1:0]    rd_owner;
  logic                          ge, up, hit_start, last;

  // per-server availability widened to the owner field range
  for (genvar k = 0; k < chrl_pkg::SID_N; k++) begin : g_up
    if (k < AV_W) begin : g_in
      assign up16[k] = avail_r[k];
    end else begin : g_out
      assign up16[k] = 1'b0;
    end
  end

  chrl_ram #(
    .WIDTH (chrl_pkg::ENT_W),
    .DEPTH (RING_POINTS)
  ) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_hash   = rdata[chrl_pkg::ENT_W-1:chrl_pkg::SID_W];
  assign rd_owner  = rdata[chrl_pkg::SID_W-1:0];
  assign ge        = rd_hash >= key_r;
  assign up        = up16[rd_owner];
  assign hit_start = found_r || ge;
  assign last      = (CW'(pidx_r) + CW'(1)) == n_pts;
  assign out_free  = !out_valid_r || !out_stall;
  assign waddr     = AW'(q_op.slot);
  assign wdata     = {q_op.hash, q_op.sid};
  assign raddr     = idx_r[AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    avail_nxt      = avail_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    pidx_nxt       = pidx_r;
    found_nxt      = found_r;
    anyv_nxt       = anyv_r;
    anyi_nxt       = anyi_r;
    anyo_nxt       = anyo_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_server_nxt = out_server_r;
    out_point_nxt  = out_point_r;
    av_ext         = up16;
    we             = 1'b0;
    pop            = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          pop            = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = chrl_pkg::ST_OK;
          out_server_nxt = '0;
          out_point_nxt  = '0;
          unique case (q_op.op)
            chrl_pkg::OP_WRITE: we = 1'b1;
            chrl_pkg::OP_AVAIL: begin
              av_ext[q_op.sid] = q_op.up;
              avail_nxt        = av_ext[AV_W-1:0];
            end
            chrl_pkg::OP_EMPTY: out_status_nxt = chrl_pkg::ST_NONE;
            chrl_pkg::OP_LOOKUP: begin
              // result lands when the scan finishes; the slot stays free till then
              out_valid_nxt = 1'b0;
              state_nxt     = BK_SCAN;
              key_nxt       = q_op.hash;
              idx_nxt       = '0;
              found_nxt     = 1'b0;
              anyv_nxt      = 1'b0;
            end
            default: out_status_nxt = chrl_pkg::ST_RANGE;
          endcase
        end
      end
      BK_SCAN: begin
        if (idx_r < n_pts) begin
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[AW-1:0];
        end
        if (pend_r) begin
          if ((hit_start && up) || last) begin
            state_nxt      = BK_IDLE;
            pend_nxt       = 1'b0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = chrl_pkg::ST_OK;
            if (hit_start && up) begin
              out_server_nxt = rd_owner;
              out_point_nxt  = chrl_pkg::SLOT_W'(pidx_r);
            end else if (anyv_r) begin
              // wrapped: no live successor, so take the lowest live point
              out_server_nxt = anyo_r;
              out_point_nxt  = chrl_pkg::SLOT_W'(anyi_r);
            end else if (up) begin
              out_server_nxt = rd_owner;
              out_point_nxt  = chrl_pkg::SLOT_W'(pidx_r);
            end else begin
              out_status_nxt = chrl_pkg::ST_NONE;
              out_server_nxt = '0;
              out_point_nxt  = '0;
            end
          end else begin
            found_nxt = hit_start;
            if (up && !anyv_r) begin
              anyv_nxt = 1'b1;
              anyi_nxt = pidx_r;
              anyo_nxt = rd_owner;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      avail_r     <= '1;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      avail_r     <= avail_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    pidx_r       <= pidx_nxt;
    found_r      <= found_nxt;
    anyv_r       <= anyv_nxt;
    anyi_r       <= anyi_nxt;
    anyo_r       <= anyo_nxt;
    out_status_r <= out_status_nxt;
    out_server_r <= out_server_nxt;
    out_point_r  <= out_point_nxt;
  end

  assign bk_stat.busy      = state_r == BK_SCAN;
  assign bk_stat.pop       = pop;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_chosen_server = out_server_r;
  assign out_chosen_point  = out_point_r;

endmodule
`default_nettype wire

// ----- design/consistent_hash_ring_lookup.sv -----
// Path: point writes, availability writes and rejected beats go through the front register,
//   the op queue and the result register. A lookup scans the ring table from point 0, one
//   ring-table read per cycle, to its answer; a full miss or a wrap reads every point in use.
// Throughput: one non-lookup beat per cycle while no lookup scans and out_stall is low; a
//   lookup holds the back end for the linear successor scan over the single RAM read port.
// Reset (rst_n low, synchronous): clears queue, handshakes and both config registers,
//   sets every server available; the ring table is not cleared.
`default_nettype none
`include "assert_macros.svh"
module consistent_hash_ring_lookup #(
  parameter int RING_POINTS = 4096,
  parameter int MAX_SERVERS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [chrl_pkg::FUNC_W-1:0]        in_func,
  input  wire logic [chrl_pkg::SLOT_W-1:0]        in_point_slot,
  input  wire logic [chrl_pkg::HASH_W-1:0]        in_point_hash,
  input  wire logic [chrl_pkg::SID_W-1:0]         in_server_id,
  input  wire logic                               in_server_up,
  input  wire logic [chrl_pkg::HASH_W-1:0]        in_key_hash,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [chrl_pkg::STATUS_W-1:0]           out_status,
  output logic [chrl_pkg::SID_W-1:0]              out_chosen_server,
  output logic [chrl_pkg::SLOT_W-1:0]             out_chosen_point,
  // config write port
  input  wire logic                               cfg_we,
  input  wire logic [chrl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [chrl_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int CW = $clog2(RING_POINTS + 1);

  // config registers
  logic [chrl_pkg::PIU_W-1:0] points_in_use_r, points_in_use_nxt;
  logic [chrl_pkg::SIU_W-1:0] servers_in_use_r, servers_in_use_nxt;
  logic [CW-1:0]              n_sat;

  // front -> queue -> back
  logic                 f_valid, q_ready, q_valid;
  chrl_pkg::op_t        f_op, q_op;
  chrl_pkg::bk_stat_t   bk_stat;

  always_comb begin
    points_in_use_nxt  = points_in_use_r;
    servers_in_use_nxt = servers_in_use_r;
    if (cfg_we) begin
      unique case (cfg_index)
        chrl_pkg::CFG_POINTS:  points_in_use_nxt  = cfg_wdata;
        chrl_pkg::CFG_SERVERS: servers_in_use_nxt = cfg_wdata[chrl_pkg::SIU_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_in_use_r  <= '0;
      servers_in_use_r <= '0;
    end else begin
      points_in_use_r  <= points_in_use_nxt;
      servers_in_use_r <= servers_in_use_nxt;
    end
  end

  // point count saturates at the table depth
  assign n_sat = (32'(points_in_use_r) > 32'(RING_POINTS)) ? CW'(RING_POINTS)
                                                            : CW'(points_in_use_r);

  // front: accept and classify beats, range checks done here
  chrl_front #(
    .RING_POINTS (RING_POINTS),
    .MAX_SERVERS (MAX_SERVERS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_point_slot  (in_point_slot),
    .in_point_hash  (in_point_hash),
    .in_server_id   (in_server_id),
    .in_server_up   (in_server_up),
    .in_key_hash    (in_key_hash),
    .servers_in_use (servers_in_use_r),
    .ring_empty     (n_sat == '0),
    .f_valid        (f_valid),
    .f_op           (f_op),
    .q_ready        (q_ready)
  );

  // short op queue decoupling front and back
  chrl_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_valid),
    .din   (f_op),
    .ready (q_ready),
    .valid (q_valid),
    .dout  (q_op),
    .pop   (bk_stat.pop)
  );

  // back: ring table, availability, successor scan, result register
  chrl_back #(
    .RING_POINTS (RING_POINTS),
    .MAX_SERVERS (MAX_SERVERS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .n_pts             (n_sat),
    .q_valid           (q_valid),
    .q_op              (q_op),
    .bk_stat           (bk_stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_chosen_server (out_chosen_server),
    .out_chosen_point  (out_chosen_point)
  );

  // ---- assertions ----
  `CHRL_ASSERT(a_pop_has_room, bk_stat.pop |-> (q_valid && (!out_valid || !out_stall)), "pop without queue data or result room")
  `CHRL_ASSERT(a_no_pop_in_scan, bk_stat.busy |-> !bk_stat.pop, "queue popped during scan")
  `CHRL_ASSERT(a_err_zero_fields, (out_valid && out_status != chrl_pkg::ST_OK) |-> (out_chosen_server == '0 && out_chosen_point == '0), "fields nonzero on error status")
  `CHRL_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid && !in_stall && !bk_stat.busy), "not idle after reset")

endmodule
`default_nettype wire
